/* sv/pdce_pkg.sv */
// ----------------------------------------------------------------------------
// pdce_pkg
// Shared types, constants and helpers for the Pelco-D command frame encoder.
// ----------------------------------------------------------------------------
package pdce_pkg;

    // Action codes carried on the func field
    typedef enum logic [3:0] {
        FUNC_IRIS_OPEN   = 4'd0,
        FUNC_IRIS_CLOSE  = 4'd1,
        FUNC_FOCUS_NEAR  = 4'd2,
        FUNC_FOCUS_FAR   = 4'd3,
        FUNC_ZOOM_IN     = 4'd4,
        FUNC_ZOOM_OUT    = 4'd5,
        FUNC_TILT_DOWN   = 4'd6,
        FUNC_TILT_UP     = 4'd7,
        FUNC_PAN_LEFT    = 4'd8,
        FUNC_PAN_RIGHT   = 4'd9,
        FUNC_CALL_PRESET = 4'd10,
        FUNC_CLR_PRESET  = 4'd11,
        FUNC_SET_PRESET  = 4'd12,
        FUNC_WIPER       = 4'd13
    } t_func;

    // Register map (index taken from paddr[2])
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_ADDR   = 1'b1;
    localparam int   PADDR_W    = 3;

    // Frame constants
    localparam logic [7:0] SYNC_BYTE     = 8'hFF;
    localparam logic [7:0] ADDR_RESET    = 8'h01;

    // Motion bits in command 2
    localparam logic [7:0] TILT_UP_BIT   = 8'h08;
    localparam logic [7:0] TILT_DOWN_BIT = 8'h10;
    localparam logic [7:0] PAN_LEFT_BIT  = 8'h04;
    localparam logic [7:0] PAN_RIGHT_BIT = 8'h02;

    // Lens bits
    localparam logic [7:0] IRIS_OPEN_BIT  = 8'h02;
    localparam logic [7:0] IRIS_CLOSE_BIT = 8'h04;
    localparam logic [7:0] FOCUS_NEAR_BIT = 8'h01;
    localparam logic [7:0] FOCUS_FAR_BIT  = 8'h80;
    localparam logic [7:0] ZOOM_IN_BIT    = 8'h20;
    localparam logic [7:0] ZOOM_OUT_BIT   = 8'h40;

    // Preset and auxiliary command-2 codes
    localparam logic [7:0] CMD_CALL_PRESET = 8'h07;
    localparam logic [7:0] CMD_CLR_PRESET  = 8'h05;
    localparam logic [7:0] CMD_SET_PRESET  = 8'h03;
    localparam logic [7:0] CMD_CALL_94     = 8'h11;
    localparam logic [7:0] CMD_CALL_44     = 8'h23;
    localparam logic [7:0] CMD_SET_42      = 8'h1F;
    localparam logic [7:0] CMD_SET_43      = 8'h21;
    localparam logic [7:0] CMD_WIPER_OFF   = 8'h0B;
    localparam logic [7:0] CMD_WIPER_ON    = 8'h09;

    // Vendor pattern preset numbers
    localparam logic [7:0] PRESET_CALL_94 = 8'd94;
    localparam logic [7:0] PRESET_CALL_44 = 8'd44;
    localparam logic [7:0] PRESET_SET_42  = 8'd42;
    localparam logic [7:0] PRESET_SET_43  = 8'd43;

    // Speed scale factors
    localparam logic [7:0] PAN_SCALE  = 8'd180;
    localparam logic [7:0] TILT_SCALE = 8'd60;

    // Frame descriptor handed from front to back
    typedef struct packed {
        logic       err;
        logic [7:0] addr;
        logic [7:0] cmd1;
        logic [7:0] cmd2;
        logic [7:0] pan;
        logic [7:0] tilt;
        logic [7:0] csum;
    } t_frame;

    // Merge one axis direction into the previous motion command
    function automatic logic [7:0] merge_dir(input logic [7:0] prev,
                                             input logic [7:0] speed,
                                             input logic [7:0] set_bit,
                                             input logic [7:0] opp_bit);
        logic [7:0] res;
        if (speed == 8'd0) begin
            res = prev & ~set_bit;
        end else begin
            res = (prev | set_bit) & ~opp_bit;
        end
        return res;
    endfunction

    // floor(p * k / 255) via reciprocal: (x + (x >> 8) + 1) >> 8, exact for x < 65535
    function automatic logic [7:0] scale_speed(input logic [7:0] p, input logic [7:0] k);
        logic [15:0] prod;
        logic [15:0] adj;
        prod = 16'(p) * 16'(k);
        adj  = prod + {8'd0, prod[15:8]} + 16'd1;
        return adj[15:8];
    endfunction

endpackage

/* sv/pdce_front.sv */
// ----------------------------------------------------------------------------
// pdce_front
// Register port, command decode and motion state; builds one frame descriptor
// per accepted command while the encoder is enabled.
// ----------------------------------------------------------------------------
module pdce_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdce_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [3:0]                    i_func,
    input  logic [7:0]                    i_param,
    // towards queue
    input  logic                          i_q_full,
    output logic                          o_push,
    output pdce_pkg::t_frame              o_frame
);

    logic       r_enable;
    logic [7:0] r_dev_addr;
    logic [7:0] r_last_cmd;
    logic [7:0] r_pan;
    logic [7:0] r_tilt;

    logic       wr_en;
    logic       accept;
    logic       store;
    logic       err;
    logic [7:0] cmd1;
    logic [7:0] cmd2;
    logic [7:0] pan;
    logic [7:0] tilt;
    logic [7:0] csum;

    // register writes
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_dev_addr <= pdce_pkg::ADDR_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                pdce_pkg::REG_ENABLE: r_enable   <= pwdata[0];
                pdce_pkg::REG_ADDR:   r_dev_addr <= pwdata[7:0];
                default:              r_enable   <= r_enable;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[2])
            pdce_pkg::REG_ENABLE: prdata = {31'd0, r_enable};
            pdce_pkg::REG_ADDR:   prdata = {24'd0, r_dev_addr};
            default:              prdata = 32'd0;
        endcase
    end

    // command decode
    always_comb begin
        err  = 1'b0;
        cmd1 = 8'd0;
        cmd2 = 8'd0;
        pan  = 8'd0;
        tilt = 8'd0;
        unique case (i_func)
            pdce_pkg::FUNC_IRIS_OPEN: begin
                if (i_param != 8'd0) cmd1 = pdce_pkg::IRIS_OPEN_BIT;
            end
            pdce_pkg::FUNC_IRIS_CLOSE: begin
                if (i_param != 8'd0) cmd1 = pdce_pkg::IRIS_CLOSE_BIT;
            end
            pdce_pkg::FUNC_FOCUS_NEAR: begin
                if (i_param != 8'd0) cmd1 = pdce_pkg::FOCUS_NEAR_BIT;
            end
            pdce_pkg::FUNC_FOCUS_FAR: begin
                if (i_param != 8'd0) cmd2 = pdce_pkg::FOCUS_FAR_BIT;
            end
            pdce_pkg::FUNC_ZOOM_IN: begin
                if (i_param != 8'd0) cmd2 = pdce_pkg::ZOOM_IN_BIT;
            end
            pdce_pkg::FUNC_ZOOM_OUT: begin
                if (i_param != 8'd0) cmd2 = pdce_pkg::ZOOM_OUT_BIT;
            end
            pdce_pkg::FUNC_TILT_DOWN, pdce_pkg::FUNC_TILT_UP: begin
                if (i_func == pdce_pkg::FUNC_TILT_DOWN) begin
                    cmd2 = pdce_pkg::merge_dir(r_last_cmd, i_param,
                               pdce_pkg::TILT_DOWN_BIT, pdce_pkg::TILT_UP_BIT);
                end else begin
                    cmd2 = pdce_pkg::merge_dir(r_last_cmd, i_param,
                               pdce_pkg::TILT_UP_BIT, pdce_pkg::TILT_DOWN_BIT);
                end
                // keep pan speed only while pan still moves
                if ((cmd2 & (pdce_pkg::PAN_LEFT_BIT | pdce_pkg::PAN_RIGHT_BIT)) != 8'd0)
                    pan = r_pan;
                tilt = pdce_pkg::scale_speed(i_param, pdce_pkg::TILT_SCALE);
            end
            pdce_pkg::FUNC_PAN_LEFT, pdce_pkg::FUNC_PAN_RIGHT: begin
                if (i_func == pdce_pkg::FUNC_PAN_LEFT) begin
                    cmd2 = pdce_pkg::merge_dir(r_last_cmd, i_param,
                               pdce_pkg::PAN_LEFT_BIT, pdce_pkg::PAN_RIGHT_BIT);
                end else begin
                    cmd2 = pdce_pkg::merge_dir(r_last_cmd, i_param,
                               pdce_pkg::PAN_RIGHT_BIT, pdce_pkg::PAN_LEFT_BIT);
                end
                pan = pdce_pkg::scale_speed(i_param, pdce_pkg::PAN_SCALE);
                // keep tilt speed only while tilt still moves
                if ((cmd2 & (pdce_pkg::TILT_UP_BIT | pdce_pkg::TILT_DOWN_BIT)) != 8'd0)
                    tilt = r_tilt;
            end
            pdce_pkg::FUNC_CALL_PRESET: begin
                if (i_param == 8'd0) begin
                    err = 1'b1;
                end else if (i_param == pdce_pkg::PRESET_CALL_94) begin
                    cmd2 = pdce_pkg::CMD_CALL_94;
                end else if (i_param == pdce_pkg::PRESET_CALL_44) begin
                    cmd2 = pdce_pkg::CMD_CALL_44;
                end else begin
                    cmd2 = pdce_pkg::CMD_CALL_PRESET;
                    tilt = i_param;
                end
            end
            pdce_pkg::FUNC_CLR_PRESET: begin
                if (i_param == 8'd0) begin
                    err = 1'b1;
                end else begin
                    cmd2 = pdce_pkg::CMD_CLR_PRESET;
                    tilt = i_param;
                end
            end
            pdce_pkg::FUNC_SET_PRESET: begin
                if (i_param == 8'd0) begin
                    err = 1'b1;
                end else if (i_param == pdce_pkg::PRESET_SET_42) begin
                    cmd2 = pdce_pkg::CMD_SET_42;
                end else if (i_param == pdce_pkg::PRESET_SET_43) begin
                    cmd2 = pdce_pkg::CMD_SET_43;
                end else begin
                    cmd2 = pdce_pkg::CMD_SET_PRESET;
                    tilt = i_param;
                end
            end
            pdce_pkg::FUNC_WIPER: begin
                cmd2 = (i_param == 8'd0) ? pdce_pkg::CMD_WIPER_OFF : pdce_pkg::CMD_WIPER_ON;
                tilt = 8'd1;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    // checksum over address, both command bytes and both speeds
    assign csum = r_dev_addr + cmd1 + cmd2 + pan + tilt;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && r_enable;
    assign store      = o_push && !err && !cmd2[0];

    assign o_frame.err  = err;
    assign o_frame.addr = r_dev_addr;
    assign o_frame.cmd1 = cmd1;
    assign o_frame.cmd2 = cmd2;
    assign o_frame.pan  = pan;
    assign o_frame.tilt = tilt;
    assign o_frame.csum = csum;

    // motion state: updated by every pushed error-free frame with command-2 bit 0 clear (motion and lens frames)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cmd <= 8'd0;
            r_pan      <= 8'd0;
            r_tilt     <= 8'd0;
        end else if (store) begin
            r_last_cmd <= cmd2;
            r_pan      <= pan;
            r_tilt     <= tilt;
        end
    end

endmodule

/* sv/pdce_queue.sv */
// ----------------------------------------------------------------------------
// pdce_queue
// Two-entry descriptor queue between decode and byte serialiser.
// ----------------------------------------------------------------------------
module pdce_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pdce_pkg::t_frame i_frame,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output pdce_pkg::t_frame o_head
);

    pdce_pkg::t_frame r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/pdce_back.sv */
// ----------------------------------------------------------------------------
// pdce_back
// Serialises the head descriptor into frame bytes through an output register.
// ----------------------------------------------------------------------------
module pdce_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  pdce_pkg::t_frame i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte,
    output logic             o_error
);

    localparam logic [2:0] POS_SYNC = 3'd0;
    localparam logic [2:0] POS_ADDR = 3'd1;
    localparam logic [2:0] POS_CMD1 = 3'd2;
    localparam logic [2:0] POS_CMD2 = 3'd3;
    localparam logic [2:0] POS_PAN  = 3'd4;
    localparam logic [2:0] POS_TILT = 3'd5;
    localparam logic [2:0] POS_CSUM = 3'd6;

    logic       r_out_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_err;
    logic [2:0] r_pos;

    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    assign load  = !r_out_valid || i_out_ready;
    assign last  = i_head.err || (r_pos == POS_CSUM);
    assign o_pop = load && i_q_valid && last;

    // byte select from head descriptor
    always_comb begin
        case (r_pos)
            POS_SYNC: sel_byte = pdce_pkg::SYNC_BYTE;
            POS_ADDR: sel_byte = i_head.addr;
            POS_CMD1: sel_byte = i_head.cmd1;
            POS_CMD2: sel_byte = i_head.cmd2;
            POS_PAN:  sel_byte = i_head.pan;
            POS_TILT: sel_byte = i_head.tilt;
            POS_CSUM: sel_byte = i_head.csum;
            default:  sel_byte = 8'd0;
        endcase
        if (i_head.err) sel_byte = 8'd0;
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= POS_SYNC;
        end else if (load) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_pos <= last ? POS_SYNC : r_pos + 3'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_byte <= sel_byte;
            r_last <= last;
            r_err  <= i_head.err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;
    assign o_error      = r_err;

endmodule

/* sv/pelco_d_command_frame_encoder.sv */
// ----------------------------------------------------------------------------
// pelco_d_command_frame_encoder
// Turns camera commands into seven-byte Pelco-D frames, one byte a transfer.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+--------------------------------
//  command   | in        | i_in_valid / o_in_ready    | i_func, i_param
//  frame     | out       | o_out_valid / i_out_ready  | o_frame_byte, o_last_byte, o_error
//  registers | in        | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
//  A command is decoded in the cycle it is accepted; its frame then leaves at
//  one byte per cycle unless stalled, seven bytes per frame (one for an error
//  item), paced by the byte serialiser. A two-entry queue lets commands be
//  taken while a frame is being sent. Disabled-protocol commands are accepted
//  and dropped. Reset, synchronous and active low, clears the queue and state.
// ----------------------------------------------------------------------------
module pelco_d_command_frame_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdce_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [3:0]                    i_func,
    input  logic [7:0]                    i_param,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_frame_byte,
    output logic                          o_last_byte,
    output logic                          o_error
);

    logic             q_full;
    logic             q_valid;
    logic             push;
    logic             pop;
    pdce_pkg::t_frame frame;
    pdce_pkg::t_frame head;

    assign pready = 1'b1;

    // decode front
    pdce_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_param    (i_param),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_frame    (frame)
    );

    // descriptor queue
    pdce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (frame),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    // byte serialiser
    pdce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte),
        .o_error      (o_error)
    );

endmodule

/* sv/pdce_checker.sv */
// ----------------------------------------------------------------------------
// pdce_checker
// Port-level checks for the Pelco-D command frame encoder.
// ----------------------------------------------------------------------------
module pdce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_frame_byte,
    input logic       o_last_byte,
    input logic       o_error
);

    // no frame byte is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an error item is a single zero byte marked last
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_last_byte && (o_frame_byte == 8'd0)))
        else $error("malformed error item");

    // register port never stretches a transfer
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    // a stalled byte stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled byte keeps its value
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_frame_byte) && $stable(o_last_byte)))
        else $error("output payload changed while stalled");

endmodule

bind pelco_d_command_frame_encoder pdce_checker u_pdce_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .pready       (pready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_frame_byte (o_frame_byte),
    .o_last_byte  (o_last_byte),
    .o_error      (o_error)
);
